// File: rtl/date_day_number_converter_macros.svh
// Assertion macros shared by the date / day number converter RTL.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef DATE_DAY_NUMBER_CONVERTER_MACROS_SVH
`define DATE_DAY_NUMBER_CONVERTER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, reset disables the check.
`define DDNC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, reset disables the check.
`define DDNC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DDNC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define DDNC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: rtl/ddnc_pkg.sv
// Package for the date / day number converter: field widths, request codes,
// payload and control structs, and the month length tables. No dependencies.
package ddnc_pkg;

  localparam int DNW  = 23;  // serial day number
  localparam int DAYW = 5;
  localparam int MONW = 4;
  localparam int YRW  = 14;
  localparam int AW   = 25;  // accumulator, holds any unsaturated date sum

  localparam logic REQ_DATE   = 1'b0;  // date to day number
  localparam logic REQ_NUMBER = 1'b1;  // day number to date

  localparam logic [8:0] YEAR_DAYS = 9'd365;

  typedef struct packed {
    logic                   req_type;
    logic [DAYW-1:0]        in_day;
    logic [MONW-1:0]        in_month;
    logic [YRW-1:0]         in_year;
    logic                   in_bc;
    logic signed [DNW-1:0]  in_day_number;
  } req_t;

  typedef struct packed {
    logic signed [DNW-1:0]  out_day_number;
    logic [DAYW-1:0]        out_day;
    logic [MONW-1:0]        out_month;
    logic [YRW-1:0]         out_year;
    logic                   out_bc;
  } res_t;

  typedef struct packed {
    logic start;  // request accepted this cycle
    logic take;   // finished result moves into the output register
  } ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sts_t;

  // Length of month idx (0 = January) in a common or leap year.
  function automatic logic [DAYW-1:0] month_len(input logic lp, input logic [MONW-1:0] idx);
    logic [DAYW-1:0] len;
    case (idx)
      4'd1:    len = lp ? 5'd29 : 5'd28;
      4'd3,
      4'd5,
      4'd8,
      4'd10:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  // Days in the first 'full' months of a year, full from 0 to 12.
  function automatic logic [8:0] cum_days(input logic lp, input logic [MONW-1:0] full);
    logic [8:0] base;
    case (full)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd365;
    endcase
    return base + {8'd0, (lp && (full >= 4'd2))};
  endfunction

endpackage

// File: rtl/ddnc_if.sv
// Request and result channel interfaces of the date / day number converter.
// Depends on ddnc_pkg for field widths.
interface ddnc_in_if;
  logic                           valid;
  logic                           ready;
  logic                           req_type;
  logic [ddnc_pkg::DAYW-1:0]      in_day;
  logic [ddnc_pkg::MONW-1:0]      in_month;
  logic [ddnc_pkg::YRW-1:0]       in_year;
  logic                           in_bc;
  logic signed [ddnc_pkg::DNW-1:0] in_day_number;

  modport source (output valid, req_type, in_day, in_month, in_year, in_bc, in_day_number,
                  input ready);
  modport sink   (input valid, req_type, in_day, in_month, in_year, in_bc, in_day_number,
                  output ready);
endinterface

interface ddnc_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [ddnc_pkg::DNW-1:0] out_day_number;
  logic [ddnc_pkg::DAYW-1:0]       out_day;
  logic [ddnc_pkg::MONW-1:0]       out_month;
  logic [ddnc_pkg::YRW-1:0]        out_year;
  logic                            out_bc;

  modport source (output valid, out_day_number, out_day, out_month, out_year, out_bc,
                  input ready);
  modport sink   (input valid, out_day_number, out_day, out_month, out_year, out_bc,
                  output ready);
endinterface

// File: rtl/ddnc_core.sv
// Sequencer and shared add/subtract unit of the date / day number converter.
// Depends on ddnc_pkg and date_day_number_converter_macros.svh.
`include "date_day_number_converter_macros.svh"

module ddnc_core #(
  parameter int MAX_YEAR = 9999
) (
  input  logic           clk,
  input  logic           rst_n,
  input  ddnc_pkg::ctl_t ctl,
  input  ddnc_pkg::req_t req,
  output ddnc_pkg::sts_t sts,
  output ddnc_pkg::res_t res
);

  localparam int YW = $clog2(MAX_YEAR + 1);
  localparam int WW = (YW > ddnc_pkg::YRW) ? YW : ddnc_pkg::YRW;
  localparam int AW = ddnc_pkg::AW;
  localparam int DNW = ddnc_pkg::DNW;

  localparam logic [WW-1:0] MAX_W   = WW'(MAX_YEAR);
  localparam logic [WW-1:0] MAXM1_W = WW'(MAX_YEAR - 1);

  localparam logic signed [AW-1:0] DN_MIN = -(AW'(4194304));
  localparam logic signed [AW-1:0] DN_MAX = AW'(4194303);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_D_YEAR = 3'd1;
  localparam logic [2:0] ST_D_ADD  = 3'd2;
  localparam logic [2:0] ST_N_YEAR = 3'd3;
  localparam logic [2:0] ST_N_MON  = 3'd4;
  localparam logic [2:0] ST_N_FIN  = 3'd5;
  localparam logic [2:0] ST_DONE   = 3'd6;

  localparam logic [3:0] MON_FIRST = 4'd0;
  localparam logic [3:0] MON_LAST  = 4'd11;

  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] acc_r, acc_nxt;
  logic [WW-1:0] w_r, w_nxt;
  logic [1:0]    m4_r, m4_nxt;
  logic [6:0]    m100_r, m100_nxt;
  logic [8:0]    m400_r, m400_nxt;
  logic          prev_leap_r, prev_leap_nxt;
  logic [3:0]    mon_r, mon_nxt;
  logic          bc_r, bc_nxt;
  ddnc_pkg::req_t req_r;

  logic [AW-1:0] op_a, op_b, sum;
  logic          op_sub;
  logic          diff_neg, diff_zero;
  logic          leap_now, lp, advance, init_bc, num_bc;
  logic [8:0]    year_len;
  logic [4:0]    mlen;
  logic [3:0]    full;
  logic [9:0]    day_add;
  logic [WW-1:0] year_ext, year_out;
  logic          stop;

  // The walk year is tracked modulo 4, 100 and 400 so the leap test needs no divider.
  assign leap_now = ((m4_r == 2'd0) && (m100_r != 7'd0)) || (m400_r == 9'd0);
  // A BC date takes its month table from the year before the walk end.
  assign lp = ((req_r.req_type == ddnc_pkg::REQ_DATE) && bc_r) ? prev_leap_r : leap_now;
  assign year_len = ddnc_pkg::YEAR_DAYS + {8'd0, leap_now};
  assign mlen = ddnc_pkg::month_len(lp, mon_r);

  always_comb begin
    if (req_r.in_month == 4'd0) begin
      full = 4'd0;
    end else if (req_r.in_month >= 4'd14) begin
      full = 4'd12;
    end else begin
      full = req_r.in_month - 4'd1;
    end
  end

  assign day_add  = 10'(req_r.in_day) + 10'(ddnc_pkg::cum_days(lp, full));
  assign year_ext = WW'(req_r.in_year);
  assign num_bc   = req.in_day_number[DNW-1] || (req.in_day_number == '0);
  assign init_bc  = (req.req_type == ddnc_pkg::REQ_DATE) ? req.in_bc : num_bc;

  // Shared add/subtract unit; its sign and zero flags serve as the compare.
  assign sum       = op_a + (op_sub ? ~op_b : op_b) + AW'(op_sub);
  assign diff_neg  = sum[AW-1];
  assign diff_zero = (sum == '0);

  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    w_nxt         = w_r;
    m4_nxt        = m4_r;
    m100_nxt      = m100_r;
    m400_nxt      = m400_r;
    prev_leap_nxt = prev_leap_r;
    mon_nxt       = mon_r;
    bc_nxt        = bc_r;
    op_a          = acc_r;
    op_b          = '0;
    op_sub        = 1'b0;
    advance       = 1'b0;
    stop          = 1'b0;
    case (state_r)
      ST_IDLE: begin
        // Magnitude of a negative day number.
        op_a   = '0;
        op_b   = {{(AW-DNW){req.in_day_number[DNW-1]}}, req.in_day_number};
        op_sub = 1'b1;
        if (ctl.start) begin
          bc_nxt   = init_bc;
          w_nxt    = init_bc ? WW'(0) : WW'(1);
          m4_nxt   = init_bc ? 2'd0 : 2'd1;
          m100_nxt = init_bc ? 7'd0 : 7'd1;
          m400_nxt = init_bc ? 9'd0 : 9'd1;
          if (req.req_type == ddnc_pkg::REQ_DATE) begin
            acc_nxt   = '0;
            state_nxt = (req.in_year == '0) ? ST_DONE : ST_D_YEAR;
          end else begin
            acc_nxt   = req.in_day_number[DNW-1] ? sum : AW'(unsigned'(req.in_day_number));
            state_nxt = ST_N_YEAR;
          end
        end
      end
      ST_D_YEAR: begin
        op_b   = AW'(year_len);
        op_sub = bc_r;
        if (w_r == year_ext) begin
          state_nxt = ST_D_ADD;
        end else begin
          acc_nxt       = sum;
          prev_leap_nxt = leap_now;
          advance       = 1'b1;
        end
      end
      ST_D_ADD: begin
        op_b      = AW'(day_add);
        acc_nxt   = sum;
        state_nxt = ST_DONE;
      end
      ST_N_YEAR: begin
        op_b   = AW'(year_len);
        op_sub = 1'b1;
        if (bc_r) begin
          stop = diff_neg || (w_r >= MAXM1_W);
        end else begin
          stop = diff_neg || diff_zero || (w_r >= MAX_W);
        end
        if (stop) begin
          // When the walk ran into the year limit with days left over, clamp to the year end.
          if (bc_r && !diff_neg) begin
            acc_nxt = AW'(year_len - 9'd1);
          end else if (!bc_r && !diff_neg && !diff_zero) begin
            acc_nxt = AW'(year_len);
          end
          mon_nxt   = bc_r ? MON_LAST : MON_FIRST;
          state_nxt = ST_N_MON;
        end else begin
          acc_nxt = sum;
          advance = 1'b1;
        end
      end
      ST_N_MON: begin
        op_b   = AW'(mlen);
        op_sub = 1'b1;
        if (bc_r) begin
          if ((mon_r != MON_FIRST) && !diff_neg) begin
            acc_nxt = sum;
            mon_nxt = mon_r - 4'd1;
          end else begin
            state_nxt = ST_N_FIN;
          end
        end else begin
          if ((mon_r != MON_LAST) && !diff_neg && !diff_zero) begin
            acc_nxt = sum;
            mon_nxt = mon_r + 4'd1;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_N_FIN: begin
        // BC days were counted back from the month end.
        op_a      = AW'(mlen);
        op_b      = acc_r;
        op_sub    = 1'b1;
        acc_nxt   = sum;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (ctl.take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (advance) begin
      w_nxt    = w_r + WW'(1);
      m4_nxt   = m4_r + 2'd1;
      m100_nxt = (m100_r == 7'd99) ? 7'd0 : m100_r + 7'd1;
      m400_nxt = (m400_r == 9'd399) ? 9'd0 : m400_r + 9'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r       <= acc_nxt;
    w_r         <= w_nxt;
    m4_r        <= m4_nxt;
    m100_r      <= m100_nxt;
    m400_r      <= m400_nxt;
    prev_leap_r <= prev_leap_nxt;
    mon_r       <= mon_nxt;
    bc_r        <= bc_nxt;
    if (ctl.start) begin
      req_r <= req;
    end
  end

  assign sts.busy = (state_r != ST_IDLE);
  assign sts.done = (state_r == ST_DONE);

  assign year_out = bc_r ? (w_r + WW'(1)) : w_r;

  always_comb begin
    res = '0;
    if (req_r.req_type == ddnc_pkg::REQ_DATE) begin
      if ($signed(acc_r) < DN_MIN) begin
        res.out_day_number = DNW'(DN_MIN);
      end else if ($signed(acc_r) > DN_MAX) begin
        res.out_day_number = DNW'(DN_MAX);
      end else begin
        res.out_day_number = DNW'(acc_r);
      end
    end else begin
      res.out_day   = acc_r[ddnc_pkg::DAYW-1:0];
      res.out_month = mon_r + 4'd1;
      res.out_year  = ddnc_pkg::YRW'(year_out);
      res.out_bc    = bc_r;
    end
  end

  `DDNC_ASSERT_NOW(a_mod_track, clk, rst_n, sts.busy, (m4_r == w_r[1:0]) && (m100_r[1:0] == m4_r) && (m400_r[1:0] == m4_r), "leap counters lost track of the walk year")
  `DDNC_ASSERT_NOW(a_year_limit, clk, rst_n, state_r == ST_N_YEAR, w_r <= MAX_W, "year walk passed the year limit")
  `DDNC_ASSERT_NOW(a_date_range, clk, rst_n, sts.done && (req_r.req_type == ddnc_pkg::REQ_NUMBER), (res.out_day != 5'd0) && (res.out_month >= 4'd1) && (res.out_month <= 4'd12), "converted date out of range")

endmodule

// File: rtl/date_day_number_converter.sv
// Top level of the date / day number converter: channel handshakes and result register.
// Depends on ddnc_pkg, ddnc_if, ddnc_core and date_day_number_converter_macros.svh.
//
//   channel   direction  contents
//   in_chan   sink       req_type, date fields, serial day number
//   out_chan  source     day number, or day, month, year and era
//
// The run time of a day number request grows with the years walked, bounded by MAX_YEAR;
// that of a date request grows with in_year. The single add/subtract unit steps through
// one year per cycle, then, for a day number request, one month per cycle.
// The block takes a new request once the previous result sits in the output
// register, even while that result is stalled. Reset is synchronous, active low.
`include "date_day_number_converter_macros.svh"

module date_day_number_converter #(
  parameter int MAX_YEAR = 9999
) (
  input logic        clk,
  input logic        rst_n,
  ddnc_in_if.sink    in_chan,
  ddnc_out_if.source out_chan
);

  ddnc_pkg::ctl_t ctl;
  ddnc_pkg::sts_t sts;
  ddnc_pkg::req_t req;
  ddnc_pkg::res_t res;
  ddnc_pkg::res_t out_res_r;
  logic           out_valid_r, out_valid_nxt;

  assign req.req_type      = in_chan.req_type;
  assign req.in_day        = in_chan.in_day;
  assign req.in_month      = in_chan.in_month;
  assign req.in_year       = in_chan.in_year;
  assign req.in_bc         = in_chan.in_bc;
  assign req.in_day_number = in_chan.in_day_number;

  assign in_chan.ready = !sts.busy;
  assign ctl.start     = in_chan.valid && !sts.busy;
  assign ctl.take      = sts.done && (!out_valid_r || out_chan.ready);

  ddnc_core #(
    .MAX_YEAR (MAX_YEAR)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .req   (req),
    .sts   (sts),
    .res   (res)
  );

  always_comb begin
    if (ctl.take) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      out_res_r <= res;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.out_day_number = out_res_r.out_day_number;
  assign out_chan.out_day        = out_res_r.out_day;
  assign out_chan.out_month      = out_res_r.out_month;
  assign out_chan.out_year       = out_res_r.out_year;
  assign out_chan.out_bc         = out_res_r.out_bc;

  `DDNC_ASSERT_NEXT(a_start_busy, clk, rst_n, ctl.start, sts.busy, "request did not start")
  `DDNC_ASSERT_NEXT(a_take_valid, clk, rst_n, ctl.take, out_valid_r, "taken result not presented")
  `DDNC_ASSERT_NEXT(a_done_hold, clk, rst_n, sts.done && !ctl.take, sts.done, "result lost in core")

endmodule

// File: tb/date_day_number_converter_tb.sv
// Self-checking testbench for date_day_number_converter: directed and random requests
// in both directions, checked against a built-in date calculator.
// Depends on ddnc_pkg, ddnc_if and the converter RTL.
module date_day_number_converter_tb;

  localparam int     CLK_PERIOD   = 12;
  localparam int     MAX_YEAR     = 9999;
  localparam longint DN_LO        = -64'sd4194304;
  localparam longint DN_HI        = 64'sd4194303;
  localparam int     DRAIN_CYCLES = MAX_YEAR + 40;
  localparam int     HOLD_CYCLES  = 400;
  localparam longint LIMIT_TIME   = 64'd5_000_000 * CLK_PERIOD;

  logic clk;
  logic rst_n;

  ddnc_in_if  in_chan();
  ddnc_out_if out_chan();

  date_day_number_converter #(
    .MAX_YEAR(MAX_YEAR)
  ) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  ddnc_pkg::res_t awaited_conversions[$];
  int   error_count    = 0;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  int   hold_left      = 0;
  bit   hold_pending   = 1'b0;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(LIMIT_TIME);
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------- calendar

  function automatic int is_leap(int unsigned y);
    return ((y % 100 != 0 && y % 4 == 0) || y % 400 == 0) ? 1 : 0;
  endfunction

  function automatic int days_in_month(int lp, int idx);
    case (idx)
      1:             return lp ? 29 : 28;
      3, 5, 8, 10:   return 30;
      default:       return 31;
    endcase
  endfunction

  function automatic longint leaps_through(longint y);
    return y / 4 - y / 100 + y / 400;
  endfunction

  function automatic longint date_to_serial(int unsigned day, int unsigned month,
                                            int unsigned year, bit bc);
    longint      n;
    int          lp;
    int unsigned full;
    int unsigned m;
    longint      prev;
    if (year == 0) return 0;
    lp = is_leap(year - int'(bc));
    n = longint'(day);
    full = (month == 0) ? 0 : month - 1;
    if (full > 12) full = 12;
    for (m = 0; m < full; m++) n += longint'(days_in_month(lp, int'(m)));
    prev = longint'(year) - 1;
    if (bc) n = n - (leaps_through(prev) + 1) - 365 * longint'(year);
    else    n = n + leaps_through(prev) + 365 * prev;
    if (n < DN_LO) n = DN_LO;
    if (n > DN_HI) n = DN_HI;
    return n;
  endfunction

  function automatic ddnc_pkg::res_t serial_to_date(longint dn);
    ddnc_pkg::res_t r;
    bit             era_bc;
    int unsigned    yr;
    longint         d;
    longint         len;
    int             lp;
    int             m;
    r = '0;
    era_bc = (dn <= 0);
    yr = 1;
    d = (dn < 0) ? -dn : dn;
    if (era_bc) begin
      // Counting backwards: each BC year is leap when year - 1 is.
      len = 365 + longint'(is_leap(yr - 1));
      while (d >= len && yr < MAX_YEAR) begin
        d -= len;
        yr++;
        len = 365 + longint'(is_leap(yr - 1));
      end
      if (d >= len) d = len - 1;
      lp = is_leap(yr - 1);
      m = 11;
      while (m > 0 && d >= longint'(days_in_month(lp, m))) begin
        d -= longint'(days_in_month(lp, m));
        m--;
      end
      d = longint'(days_in_month(lp, m)) - d;
    end else begin
      len = 365 + longint'(is_leap(yr));
      while (d > len && yr < MAX_YEAR) begin
        d -= len;
        yr++;
        len = 365 + longint'(is_leap(yr));
      end
      if (d > len) d = len;
      lp = is_leap(yr);
      m = 0;
      while (m < 11 && d > longint'(days_in_month(lp, m))) begin
        d -= longint'(days_in_month(lp, m));
        m++;
      end
    end
    r.out_day   = d[ddnc_pkg::DAYW-1:0];
    r.out_month = ddnc_pkg::MONW'(m + 1);
    r.out_year  = yr[ddnc_pkg::YRW-1:0];
    r.out_bc    = era_bc;
    return r;
  endfunction

  function automatic ddnc_pkg::res_t convert_request(ddnc_pkg::req_t q);
    ddnc_pkg::res_t r;
    longint         n;
    r = '0;
    if (q.req_type == ddnc_pkg::REQ_DATE) begin
      n = date_to_serial(32'(q.in_day), 32'(q.in_month), 32'(q.in_year), q.in_bc);
      r.out_day_number = n[ddnc_pkg::DNW-1:0];
    end else begin
      r = serial_to_date(longint'($signed(q.in_day_number)));
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- requests

  // Random background for the fields a request does not use.
  function automatic ddnc_pkg::req_t random_fill();
    logic [63:0] noise;
    noise = {$urandom, $urandom};
    return noise[$bits(ddnc_pkg::req_t)-1:0];
  endfunction

  function automatic ddnc_pkg::req_t make_date(int day, int month, int year, bit bc);
    ddnc_pkg::req_t q;
    q = random_fill();
    q.req_type = ddnc_pkg::REQ_DATE;
    q.in_day   = day[ddnc_pkg::DAYW-1:0];
    q.in_month = month[ddnc_pkg::MONW-1:0];
    q.in_year  = year[ddnc_pkg::YRW-1:0];
    q.in_bc    = bc;
    return q;
  endfunction

  function automatic ddnc_pkg::req_t make_number(int dn);
    ddnc_pkg::req_t q;
    q = random_fill();
    q.req_type      = ddnc_pkg::REQ_NUMBER;
    q.in_day_number = dn[ddnc_pkg::DNW-1:0];
    return q;
  endfunction

  // Mostly short walks; about one request in ten spans the full range.
  function automatic ddnc_pkg::req_t random_request();
    ddnc_pkg::req_t q;
    int             dn;
    q = random_fill();
    q.req_type = 1'($urandom_range(1));
    q.in_bc    = 1'($urandom_range(1));
    if ($urandom_range(9) == 0) begin
      q.in_year = ddnc_pkg::YRW'($urandom_range(MAX_YEAR));
      dn = int'($urandom);
    end else begin
      q.in_year = ddnc_pkg::YRW'($urandom_range(300));
      dn = int'($urandom_range(220000)) - 110000;
    end
    q.in_day_number = dn[ddnc_pkg::DNW-1:0];
    if ($urandom_range(15) == 0) begin
      q.in_day   = ddnc_pkg::DAYW'($urandom_range(31));
      q.in_month = ddnc_pkg::MONW'($urandom_range(15));
    end else begin
      q.in_day   = ddnc_pkg::DAYW'($urandom_range(31, 1));
      q.in_month = ddnc_pkg::MONW'($urandom_range(12, 1));
    end
    return q;
  endfunction

  // Called right after a rising edge; returns at the edge where the request is taken.
  task automatic offer_request(input ddnc_pkg::req_t q);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid         <= 1'b1;
    in_chan.req_type      <= q.req_type;
    in_chan.in_day        <= q.in_day;
    in_chan.in_month      <= q.in_month;
    in_chan.in_year       <= q.in_year;
    in_chan.in_bc         <= q.in_bc;
    in_chan.in_day_number <= q.in_day_number;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    awaited_conversions.push_back(convert_request(q));
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  task automatic check_conversion(ddnc_pkg::res_t got);
    ddnc_pkg::res_t want;
    if (awaited_conversions.size() == 0) begin
      $display("%0t: result with no request outstanding: day number %0d, date %0d/%0d/%0d bc %0d",
               $time, got.out_day_number, got.out_day, got.out_month, got.out_year, got.out_bc);
      error_count++;
    end else begin
      want = awaited_conversions.pop_front();
      report_field("day number", longint'($signed(want.out_day_number)),
                   longint'($signed(got.out_day_number)));
      report_field("day", longint'(want.out_day), longint'(got.out_day));
      report_field("month", longint'(want.out_month), longint'(got.out_month));
      report_field("year", longint'(want.out_year), longint'(got.out_year));
      report_field("bc flag", longint'(want.out_bc), longint'(got.out_bc));
    end
  endtask

  // Result side: checks each handshake and drives ready, including the long hold-off.
  initial begin
    ddnc_pkg::res_t got;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_chan.valid && out_chan.ready) begin
        got.out_day_number = out_chan.out_day_number;
        got.out_day        = out_chan.out_day;
        got.out_month      = out_chan.out_month;
        got.out_year       = out_chan.out_year;
        got.out_bc         = out_chan.out_bc;
        check_conversion(got);
      end
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_date_directed();
    offer_request(make_date(1, 1, 1, 1'b0));
    offer_request(make_date(31, 12, MAX_YEAR, 1'b0));
    offer_request(make_date(15, 6, 0, 1'b0));
    offer_request(make_date(15, 6, 0, 1'b1));
    offer_request(make_date(1, 1, MAX_YEAR, 1'b1));
    offer_request(make_date(31, 12, 1, 1'b1));
    offer_request(make_date(29, 2, 4, 1'b0));
    offer_request(make_date(29, 2, 1, 1'b1));
    // Month zero with day zero, month past twelve, and a day past the month's end.
    offer_request(make_date(0, 0, 2000, 1'b0));
    offer_request(make_date(31, 15, 1900, 1'b0));
    offer_request(make_date(31, 2, 2100, 1'b1));
    // Years past the normal range push the sum into saturation.
    offer_request(make_date(31, 12, 16383, 1'b0));
    offer_request(make_date(1, 1, 16383, 1'b1));
  endtask

  task automatic test_number_directed();
    offer_request(make_number(1));
    offer_request(make_number(0));
    offer_request(make_number(-1));
    offer_request(make_number(366));
    offer_request(make_number(60));
    offer_request(make_number(-365));
    offer_request(make_number(-366));
    offer_request(make_number(3652059));
    offer_request(make_number(3652060));
    offer_request(make_number(4194303));
    offer_request(make_number(-4194304));
    offer_request(make_number(-3652425));
  endtask

  task automatic run_random_phase(int send_pct, int recv_pct, int count);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    repeat (count) offer_request(random_request());
  endtask

  task automatic test_random_traffic();
    run_random_phase(0, 0, 18);
    run_random_phase(86, 0, 18);
    run_random_phase(0, 86, 18);
    run_random_phase(6, 6, 18);
  endtask

  // The result side holds off while short requests keep coming, so the input backs up.
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_pending = 1'b1;
    repeat (10) begin
      if ($urandom_range(1) == 0)
        offer_request(make_date(int'($urandom_range(28, 1)), int'($urandom_range(12, 1)),
                                int'($urandom_range(20)), 1'($urandom_range(1))));
      else
        offer_request(make_number(int'($urandom_range(8000)) - 4000));
    end
  endtask

  task automatic finish_run();
    in_chan.valid <= 1'b0;
    while (awaited_conversions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  endtask

  initial begin
    rst_n                 <= 1'b0;
    in_chan.valid         <= 1'b0;
    in_chan.req_type      <= ddnc_pkg::REQ_DATE;
    in_chan.in_day        <= '0;
    in_chan.in_month      <= '0;
    in_chan.in_year       <= '0;
    in_chan.in_bc         <= 1'b0;
    in_chan.in_day_number <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_date_directed();
    test_number_directed();
    test_random_traffic();
    test_backpressure();
    finish_run();
  end

endmodule
